/* rtl/u8san_pkg.sv */
// Package for the UTF-8 stream sanitizer: byte classification types,
// character constants and the classification function.
// Used by every module of the block; depends on nothing.
`default_nettype none

package u8san_pkg;

    localparam logic [7:0] REPLACEMENT_RESET = 8'd63;

    localparam logic [7:0] CTRL_LIMIT  = 8'd32;
    localparam logic [7:0] DEL_CHAR    = 8'd127;
    localparam logic [7:0] TAB_CHAR    = 8'd9;
    localparam logic [7:0] LF_CHAR     = 8'd10;
    localparam logic [7:0] CR_CHAR     = 8'd13;
    localparam logic [7:0] EURO_SRC    = 8'd128;
    localparam logic [7:0] NEL_SRC     = 8'd133;
    localparam logic [7:0] EURO_BYTE0  = 8'd226;
    localparam logic [7:0] EURO_BYTE1  = 8'd130;
    localparam logic [7:0] EURO_BYTE2  = 8'd172;

    localparam logic [7:0] CONT_LO     = 8'd128;
    localparam logic [7:0] CONT_HI     = 8'd192;
    localparam logic [7:0] LEAD2_LO    = 8'd194;
    localparam logic [7:0] LEAD3_LO    = 8'd224;
    localparam logic [7:0] LEAD4_LO    = 8'd240;
    localparam logic [7:0] LEAD4_HI    = 8'd245;
    localparam logic [7:0] C2_LEAD     = 8'd194;
    localparam logic [7:0] C2_CTRL_LIM = 8'd160;

    localparam logic [2:0] LEN_NONE    = 3'd0;
    localparam logic [2:0] LEN_TWO     = 3'd2;
    localparam logic [2:0] LEN_THREE   = 3'd3;
    localparam logic [2:0] LEN_FOUR    = 3'd4;

    typedef struct packed {
        logic [7:0] value;
        logic [2:0] len;
        logic       cont;
    } byte_info_t;

    typedef struct packed {
        byte_info_t info;
        logic       fin;
    } queue_item_t;

    function automatic byte_info_t classify(input logic [7:0] b);
        byte_info_t r;
        r.value = b;
        r.cont  = (b >= CONT_LO) && (b < CONT_HI);
        if (b >= LEAD2_LO && b < LEAD3_LO) begin
            r.len = LEN_TWO;
        end
        else if (b >= LEAD3_LO && b < LEAD4_LO) begin
            r.len = LEN_THREE;
        end
        else if (b >= LEAD4_LO && b < LEAD4_HI) begin
            r.len = LEN_FOUR;
        end
        else begin
            r.len = LEN_NONE;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/u8san_front.sv */
// Front end of the sanitizer: accepts input words, classifies each byte and
// keeps them in a two-entry queue for the scan engine.
// Depends on u8san_pkg.
`default_nettype none

module u8san_front (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_stall,
    input  wire  [7:0]             in_byte,
    input  wire                    final_in,
    output logic                   q_valid,
    output u8san_pkg::queue_item_t q_item,
    input  wire                    q_pop
);
    import u8san_pkg::*;

    queue_item_t mem [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;

    assign in_stall = (count_reg == 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem[rd_ptr_reg];
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= '{info: classify(in_byte), fin: final_in};
        end
    end

endmodule

`default_nettype wire

/* rtl/u8san_back.sv */
// Scan engine of the sanitizer: joins held bytes with the next queued byte,
// walks the sequences and drives the registered output channel.
// Depends on u8san_pkg.
`default_nettype none

module u8san_back (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    q_valid,
    input  wire u8san_pkg::queue_item_t q_item,
    output logic                   q_pop,
    input  wire  [7:0]             rep_byte,
    output logic                   out_valid,
    input  wire                    out_stall,
    output logic [7:0]             out_byte,
    output logic                   run_end,
    output logic                   final_out
);
    import u8san_pkg::*;

    typedef byte_info_t [3:0] info_buf_t;

    info_buf_t  buf_reg;
    info_buf_t  cur;
    logic       active_reg;
    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;
    logic [2:0] n_reg;
    logic [1:0] pos_reg;
    logic [1:0] k_reg;
    logic       fin_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       run_end_reg;
    logic       final_out_reg;

    logic [2:0] n;
    logic [1:0] pos;
    logic [1:0] k;
    logic       fin;
    logic       out_free;
    logic       go;
    logic       hold_now;
    logic       fail;
    logic [2:0] avail;
    logic [2:0] glen;
    logic [2:0] adv;
    logic [7:0] gbyte;
    logic       last_in_group;
    logic [2:0] pos_next;
    logic       end_after;
    logic       emit;
    logic       step_done;
    logic [2:0] base;
    info_buf_t  shifted;
    byte_info_t lead;

    function automatic logic holds(input info_buf_t b, input logic [2:0] cnt,
                                   input logic [2:0] p, input logic f);
        logic [2:0] l;
        logic       ok;
        ok = 1'b1;
        l  = LEN_NONE;
        if (p >= cnt || f)
        begin
            ok = 1'b0;
        end
        else
        begin
            l = b[p[1:0]].len;
            if (l == LEN_NONE || l <= cnt - p)
            begin
                ok = 1'b0;
            end
            for (int j = 0; j < 4; j++)
            begin
                if (3'(j) > p && 3'(j) < cnt && !b[j].cont)
                begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_end   = run_end_reg;
    assign final_out = final_out_reg;

    always_comb
    begin
        cur = buf_reg;
        if (!active_reg)
        begin
            cur[held_count_reg] = q_item.info;
        end
        n   = active_reg ? n_reg : ({1'b0, held_count_reg} + 3'd1);
        pos = active_reg ? pos_reg : 2'd0;
        k   = active_reg ? k_reg : 2'd0;
        fin = active_reg ? fin_reg : q_item.fin;
        go  = out_free && (active_reg || q_valid);
        q_pop = go && !active_reg;

        lead  = cur[pos];
        avail = n - {1'b0, pos};
        fail  = 1'b0;
        for (int j = 0; j < 4; j++)
        begin
            if (3'(j) > {1'b0, pos} && 3'(j) < {1'b0, pos} + lead.len && 3'(j) < n
                && !cur[j].cont)
            begin
                fail = 1'b1;
            end
        end
        hold_now = holds(cur, n, {1'b0, pos}, fin);

        gbyte = rep_byte;
        glen  = 3'd1;
        adv   = 3'd1;
        if (lead.len == LEN_NONE)
        begin
            if (lead.value < CTRL_LIMIT)
            begin
                if (lead.value == TAB_CHAR || lead.value == LF_CHAR
                    || lead.value == CR_CHAR)
                begin
                    gbyte = lead.value;
                end
            end
            else if (lead.value < DEL_CHAR)
            begin
                gbyte = lead.value;
            end
            else if (lead.value == EURO_SRC)
            begin
                glen = 3'd3;
                unique case (k)
                    2'd0:    gbyte = EURO_BYTE0;
                    2'd1:    gbyte = EURO_BYTE1;
                    default: gbyte = EURO_BYTE2;
                endcase
            end
            else if (lead.value == NEL_SRC)
            begin
                glen  = 3'd2;
                gbyte = (k == 2'd0) ? LF_CHAR : CR_CHAR;
            end
        end
        else if (!fail && avail >= lead.len)
        begin
            if (lead.value == C2_LEAD && cur[pos + 2'd1].value < C2_CTRL_LIM)
            begin
                adv = LEN_TWO;
            end
            else
            begin
                glen  = lead.len;
                adv   = lead.len;
                gbyte = cur[pos + k].value;
            end
        end

        last_in_group = ({1'b0, k} + 3'd1 == glen);
        pos_next      = {1'b0, pos} + adv;
        end_after     = (pos_next >= n) || holds(cur, n, pos_next, fin);
        emit          = go && !hold_now;
        step_done     = go && (hold_now || (last_in_group && end_after));

        base            = hold_now ? {1'b0, pos} : pos_next;
        held_count_next = (base < n) ? 2'(n - base) : 2'd0;
        shifted         = cur;
        for (int i = 0; i < 3; i++)
        begin
            shifted[i] = cur[2'(base + 3'(i))];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            held_count_reg <= 2'd0;
            pos_reg        <= 2'd0;
            k_reg          <= 2'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (go)
            begin
                if (step_done)
                begin
                    active_reg     <= 1'b0;
                    held_count_reg <= held_count_next;
                    pos_reg        <= 2'd0;
                    k_reg          <= 2'd0;
                end
                else
                begin
                    active_reg <= 1'b1;
                    if (last_in_group)
                    begin
                        pos_reg <= pos_next[1:0];
                        k_reg   <= 2'd0;
                    end
                    else
                    begin
                        pos_reg <= pos;
                        k_reg   <= k + 2'd1;
                    end
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            if (step_done)
            begin
                buf_reg <= shifted;
            end
            else
            begin
                buf_reg <= cur;
                n_reg   <= n;
                fin_reg <= fin;
            end
        end
        if (emit)
        begin
            out_byte_reg  <= gbyte;
            run_end_reg   <= last_in_group && end_after;
            final_out_reg <= last_in_group && end_after && fin;
        end
    end

    // A held sequence is always still short of the length its lead asks for.
    held_short_a: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg && held_count_reg != 2'd0
        |-> buf_reg[0].len > {1'b0, held_count_reg})
        else $error("held sequence is not short of its length");

    pos_range_a: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> {1'b0, pos_reg} < n_reg)
        else $error("scan position beyond the working bytes");

    idle_k_a: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> k_reg == 2'd0)
        else $error("group index left over while idle");

    final_end_a: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && final_out_reg |-> run_end_reg)
        else $error("final word without run end");

endmodule

`default_nettype wire

/* rtl/utf8_stream_sanitizer_unit.sv */
// UTF-8 stream sanitizer, top level: replacement byte register, front end
// and scan engine. Depends on u8san_pkg, u8san_front and u8san_back.
//
// Input channel: in_valid/in_stall carry one raw byte (in_byte) per word, with
// final_in set on the last byte of a string. Output channel: out_valid and
// out_stall carry one cleaned byte (out_byte) per word; run_end marks the last
// word caused by an input byte and final_out the last word of a string.
// cfg_write loads cfg_data into the replacement byte; write it only while idle.
// An accepted byte passes through a queue entry and then the output register
// before its first output word. Plain text flows at one byte per cycle while
// out_stall is low; an input byte that yields more than one word holds the
// engine until it has emitted them, and a byte that is only held yields no word.
// The two-entry queue lets the front end keep accepting while the engine is busy.
// Reset empties the queue and output register, drops any held bytes and sets
// the replacement byte to '?'. A stalled receiver freezes the output word;
// the engine and then the queue fill and in_stall rises.
`default_nettype none

module utf8_stream_sanitizer_unit (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_stall,
    input  wire  [7:0] in_byte,
    input  wire        final_in,
    output logic       out_valid,
    input  wire        out_stall,
    output logic [7:0] out_byte,
    output logic       run_end,
    output logic       final_out,
    input  wire        cfg_write,
    input  wire  [7:0] cfg_data
);
    import u8san_pkg::*;

    logic [7:0]  rep_reg;
    logic        q_valid;
    logic        q_pop;
    queue_item_t q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_reg <= REPLACEMENT_RESET;
        end
        else if (cfg_write)
        begin
            rep_reg <= cfg_data;
        end
    end

    u8san_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .final_in (final_in),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    u8san_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .rep_byte  (rep_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_end   (run_end),
        .final_out (final_out)
    );

endmodule

`default_nettype wire
